### rtl/core/obdhr_pkg.sv
// Package for the OBD mode 01 response decoder: PID codes, request kinds,
// and the ASCII hex digit decode. No dependencies.
package obdhr_pkg;

    localparam logic [7:0] HdrMode01   = 8'h41;
    localparam logic [7:0] PidRpm      = 8'h0C;
    localparam logic [7:0] PidSpeed    = 8'h0D;
    localparam logic [7:0] PidCoolant  = 8'h05;
    localparam logic [7:0] CharNul     = 8'h00;
    localparam logic [2:0] KeepMax     = 3'd4;
    localparam logic signed [14:0] TempOffset = 15'sd40;

    // Requested PID kind
    typedef enum logic [1:0] {
        REQ_RPM     = 2'd0,
        REQ_SPEED   = 2'd1,
        REQ_COOLANT = 2'd2
    } t_req_type;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex_digit;

    // Decode one ASCII character as a hex digit
    function automatic t_hex_digit hex_decode(input logic [7:0] c);
        t_hex_digit d;
        d.ok  = 1'b1;
        d.val = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.val = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.val = 4'(c - 8'h57);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

### rtl/core/obd_hex_response_decoder.sv
// OBD mode 01 response decoder: parses ASCII hex pairs, checks header, scales.
// Depends on obdhr_pkg.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------------
//  request   | in        | i_valid / o_ready  | i_char_in, i_req_type, i_end_of_reply
//  result    | out       | o_valid / i_ready  | o_reading, o_reading_valid
//
// One character is taken every cycle while o_ready is high; the character is
// parsed in the cycle it arrives. A reply's result is registered on its last
// character and shows on o_valid. A two-entry output buffer (result register plus
// skid register) lets characters keep flowing while a result waits; o_ready
// drops only when both entries are full. Reset clears the parse state and
// both buffer entries; the kept bytes are undefined until written.
module obd_hex_response_decoder
    import obdhr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char_in,
    input  logic [1:0]         i_req_type,
    input  logic               i_end_of_reply,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_reading,
    output logic               o_reading_valid
);

    // Parse state
    logic [3:0] r_first, n_first;
    logic       r_half,  n_half;
    logic [2:0] r_pairs, n_pairs;
    logic       r_term,  n_term;
    logic [7:0] r_kept [4];
    logic [7:0] n_kept [4];

    // Output buffer
    logic               r_out_valid, r_skid_valid;
    logic signed [14:0] r_out_reading, r_skid_reading;
    logic               r_out_ok, r_skid_ok;

    t_hex_digit         hex;
    logic [7:0]         pair_byte;
    logic               in_acc, out_acc, out_free;
    logic [7:0]         want_pid;
    logic [2:0]         need;
    logic               res_ok;
    logic signed [14:0] res_reading;

    assign in_acc   = i_valid && o_ready;
    assign out_acc  = r_out_valid && i_ready;
    assign out_free = !r_out_valid || out_acc;

    assign o_ready         = !r_skid_valid;
    assign o_valid         = r_out_valid;
    assign o_reading       = r_out_reading;
    assign o_reading_valid = r_out_ok;

    // Parse the incoming character into the next parse state
    always_comb begin
        hex       = hex_decode(i_char_in);
        n_first   = r_first;
        n_half    = r_half;
        n_pairs   = r_pairs;
        n_term    = r_term;
        n_kept    = r_kept;
        pair_byte = hex.ok ? {r_first, hex.val} : {4'h0, r_first};
        if (!r_term) begin
            if (i_char_in == CharNul) begin
                n_term = 1'b1;
                n_half = 1'b0;
            end else if (!r_half) begin
                if (hex.ok) begin
                    n_first = hex.val;
                    n_half  = 1'b1;
                end
            end else begin
                n_half = 1'b0;
                if (r_pairs < KeepMax) begin
                    n_kept[r_pairs[1:0]] = pair_byte;
                    n_pairs              = r_pairs + 3'd1;
                end
            end
        end
    end

    // Check header and scale the reading from the updated bytes
    always_comb begin
        case (i_req_type)
            REQ_RPM: begin
                want_pid = PidRpm;
                need     = 3'd4;
            end
            REQ_SPEED: begin
                want_pid = PidSpeed;
                need     = 3'd3;
            end
            REQ_COOLANT: begin
                want_pid = PidCoolant;
                need     = 3'd3;
            end
            default: begin
                want_pid = 8'h00;
                need     = 3'd0;
            end
        endcase
        res_ok = (need != 3'd0) && (n_pairs >= need)
                 && (n_kept[0] == HdrMode01) && (n_kept[1] == want_pid);
        res_reading = 15'sd0;
        if (res_ok) begin
            case (i_req_type)
                REQ_RPM:   res_reading = $signed({1'b0, n_kept[2], n_kept[3][7:2]});
                REQ_SPEED: res_reading = $signed({7'b0, n_kept[2]});
                default:   res_reading = $signed({7'b0, n_kept[2]}) - TempOffset;
            endcase
        end
    end

    // Advance parse state; clear it after the last character of a reply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 4'h0;
            r_half  <= 1'b0;
            r_pairs <= 3'd0;
            r_term  <= 1'b0;
        end else if (in_acc) begin
            if (i_end_of_reply) begin
                r_first <= 4'h0;
                r_half  <= 1'b0;
                r_pairs <= 3'd0;
                r_term  <= 1'b0;
            end else begin
                r_first <= n_first;
                r_half  <= n_half;
                r_pairs <= n_pairs;
                r_term  <= n_term;
            end
        end
    end

    // Kept bytes carry no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kept <= n_kept;
        end
    end

    // Output buffer control: fill result register first, else hold in skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc && i_end_of_reply;
                end
            end else if (in_acc && i_end_of_reply) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Output buffer data
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_reading <= r_skid_reading;
                r_out_ok      <= r_skid_ok;
            end else begin
                r_out_reading <= res_reading;
                r_out_ok      <= res_ok;
            end
        end else if (in_acc && i_end_of_reply) begin
            r_skid_reading <= res_reading;
            r_skid_ok      <= res_ok;
        end
    end

    // Skid entry is only used behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while result register empty");

    // Byte count never passes the keep limit
    a_pairs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pairs <= KeepMax)
        else $error("byte count above keep limit");

    // Invalid replies read as zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reading_valid) |-> (o_reading == 15'sd0))
        else $error("invalid result with nonzero reading");

    // Last character yields a result and a cleared parse state
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_reply) |=> (o_valid && r_pairs == 3'd0 && !r_half && !r_term))
        else $error("last character did not produce result or clear state");

    // Non-final characters never create a result on an empty buffer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(in_acc && i_end_of_reply)) |=> !o_valid)
        else $error("result appeared without a last character");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for obd_hex_response_decoder: random reply text in, scaled readings checked
// against an in-bench reply decoder. Depends on obdhr_pkg and the decoder RTL.
module tb;
    import obdhr_pkg::*;

    localparam logic [1:0] ReqUnknown = 2'd3;
    localparam logic [7:0] CharCr     = 8'h0D;
    localparam logic [7:0] CharSpace  = 8'h20;
    localparam int         CycleLimit = 400000;
    localparam int         RandomItems = 1800;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] req;
        logic       last;
    } t_reply_char;

    typedef struct packed {
        logic signed [14:0] reading;
        logic               ok;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_char_in = 8'h00;
    logic [1:0]         i_req_type = 2'd0;
    logic               i_end_of_reply = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [14:0] o_reading;
    logic               o_reading_valid;

    obd_hex_response_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_in      (i_char_in),
        .i_req_type     (i_req_type),
        .i_end_of_reply (i_end_of_reply),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_reading      (o_reading),
        .o_reading_valid(o_reading_valid)
    );

    t_reply_char pending_chars[$];
    t_reading    expected_readings[$];
    t_reply_char sent_char;
    t_reading    oldest_reading;
    int          queued_count = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          pattern_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;

    // Reply parse state tracked alongside the decoder
    logic [3:0]  first_nibble = 4'h0;
    logic        half_pending = 1'b0;
    logic [2:0]  byte_count = 3'd0;
    logic [7:0]  reply_bytes[4];
    logic        nul_seen = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hex digit value, or -1 for any other character
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        if (n < 4'd10) return 8'("0") + 8'(n);
        if ($urandom_range(0, 1) == 0) return 8'("a") + 8'(n) - 8'd10;
        return 8'("A") + 8'(n) - 8'd10;
    endfunction

    // Nonzero character that is not a hex digit
    function automatic logic [7:0] pick_filler();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (nibble_of(c) >= 0);
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Advance the reply parse by one accepted request; on the last one, queue the reading
    task automatic decode_reply_char(input t_reply_char r);
        int         d;
        int         need;
        int         v;
        logic [7:0] b;
        logic [7:0] pid;
        t_reading   want;
        d = nibble_of(r.ch);
        if (!nul_seen) begin
            if (r.ch == CharNul) begin
                nul_seen = 1'b1;
                half_pending = 1'b0;
            end else if (!half_pending) begin
                if (d >= 0) begin
                    first_nibble = 4'(d);
                    half_pending = 1'b1;
                end
            end else begin
                b = (d >= 0) ? {first_nibble, 4'(d)} : {4'h0, first_nibble};
                half_pending = 1'b0;
                if (byte_count < KeepMax) begin
                    reply_bytes[byte_count[1:0]] = b;
                    byte_count++;
                end
            end
        end
        if (r.last) begin
            want = '0;
            case (r.req)
                REQ_RPM: begin
                    pid = PidRpm;
                    need = 4;
                end
                REQ_SPEED: begin
                    pid = PidSpeed;
                    need = 3;
                end
                REQ_COOLANT: begin
                    pid = PidCoolant;
                    need = 3;
                end
                default: begin
                    pid = 8'h00;
                    need = 0;
                end
            endcase
            if (need != 0 && int'(byte_count) >= need &&
                reply_bytes[0] == HdrMode01 && reply_bytes[1] == pid) begin
                want.ok = 1'b1;
                case (r.req)
                    REQ_RPM: want.reading = 15'({reply_bytes[2], reply_bytes[3]} >> 2);
                    REQ_SPEED: want.reading = 15'(reply_bytes[2]);
                    default: begin
                        v = int'(reply_bytes[2]) - int'(TempOffset);
                        want.reading = v[14:0];
                    end
                endcase
            end
            expected_readings.push_back(want);
            first_nibble = 4'h0;
            half_pending = 1'b0;
            byte_count = 3'd0;
            nul_seen = 1'b0;
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic [1:0] req, input logic last);
        t_reply_char r;
        r.ch = ch;
        r.req = req;
        r.last = last;
        pending_chars.push_back(r);
        queued_count++;
    endtask

    task automatic push_text(input string s, input logic [1:0] req, input logic mark_last);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], req, mark_last && (i == s.len() - 1));
        end
    endtask

    // Emit one byte as a hex pair, with optional separator and a rare bad second digit
    task automatic queue_byte_pair(input logic [7:0] b, input logic [1:0] req);
        logic [7:0] second;
        if ($urandom_range(0, 1) == 0) begin
            push_char(CharSpace, req, 1'b0);
        end else if ($urandom_range(0, 15) == 0) begin
            push_char(pick_filler(), req, 1'b0);
        end
        push_char(hex_ascii(b[7:4]), req, 1'b0);
        second = hex_ascii(b[3:0]);
        if ($urandom_range(0, 19) == 0) second = pick_filler();
        push_char(second, req, 1'b0);
    endtask

    // Build one random reply: mostly well formed, some noise, some one-character bursts
    task automatic queue_random_reply();
        logic [1:0] req;
        logic [7:0] body[$];
        logic [7:0] pid;
        int         kind;
        int         n_data;
        int         n;
        kind = $urandom_range(0, 99);
        req = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 19) == 0) req = ReqUnknown;
        if (kind < 70) begin
            body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : HdrMode01);
            case (req)
                REQ_RPM: pid = PidRpm;
                REQ_SPEED: pid = PidSpeed;
                default: pid = PidCoolant;
            endcase
            if ($urandom_range(0, 7) == 0) begin
                pid = ($urandom_range(0, 1) == 0) ? 8'($urandom) : PidSpeed;
            end
            body.push_back(pid);
            if ($urandom_range(0, 9) == 0) n_data = $urandom_range(0, 4);
            else n_data = (req == REQ_RPM) ? 2 : 1;
            for (int i = 0; i < n_data; i++) begin
                case ($urandom_range(0, 7))
                    0: body.push_back(8'h00);
                    1: body.push_back(8'hFF);
                    default: body.push_back(8'($urandom));
                endcase
            end
            foreach (body[i]) queue_byte_pair(body[i], req);
            // Terminate early and trail some garbage now and then
            if ($urandom_range(0, 9) == 0) begin
                push_char(CharNul, req, 1'b0);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) push_char(8'($urandom), req, 1'b0);
            end
            case ($urandom_range(0, 3))
                0, 1: push_char(CharCr, req, 1'b1);
                2: push_char(8'($urandom), req, 1'b1);
                default: push_char(hex_ascii(4'($urandom)), req, 1'b1);
            endcase
        end else if (kind < 85) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) push_char(8'($urandom), req, i == n - 1);
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                push_char(8'($urandom), 2'($urandom_range(0, 3)), 1'b1);
            end
        end
    endtask

    task automatic wait_for_drain();
        do begin
            @(negedge i_clk);
        end while (pending_chars.size() != 0 || i_valid || expected_readings.size() != 0);
    endtask

    // Drive requests in bursts with random gaps; hold payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                decode_reply_char(sent_char);
            end
            if (i_valid && !o_ready) begin
                // hold the current request
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
                sent_char = pending_chars.pop_front();
                i_char_in <= sent_char.ch;
                i_req_type <= sent_char.req;
                i_end_of_reply <= sent_char.last;
                i_valid <= 1'b1;
                if (burst_left == 0) burst_left = $urandom_range(1, 48);
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Stall the result side on a rotating pattern that changes now and then
    always @(posedge i_clk) begin
        if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom) | 16'h0001;
                2: ready_pattern = 16'h0101;
                default: ready_pattern = 16'h0001;
            endcase
            pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        i_ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    // Check each accepted reading against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected reading %0d valid %0b",
                                          o_reading, o_reading_valid));
            end else begin
                oldest_reading = expected_readings.pop_front();
                if (o_reading !== oldest_reading.reading) begin
                    report_mismatch($sformatf("reading %0d, want %0d",
                                              o_reading, oldest_reading.reading));
                end
                if (o_reading_valid !== oldest_reading.ok) begin
                    report_mismatch($sformatf("reading_valid %0b, want %0b",
                                              o_reading_valid, oldest_reading.ok));
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: rpm at full scale with mixed case digits
        push_text("410cFFFf", REQ_RPM, 1'b1);
        // Coolant at its lowest reading, reply ended by NUL on the last character
        push_text("410500", REQ_COOLANT, 1'b0);
        push_char(CharNul, REQ_COOLANT, 1'b1);
        // Skipped character, then a half pair dropped at the end of an unknown request
        push_char(8'hFF, ReqUnknown, 1'b0);
        push_char("A", ReqUnknown, 1'b1);
        // NUL right after a first digit leaves the speed reply short
        push_text("410D7", REQ_SPEED, 1'b0);
        push_char(CharNul, REQ_SPEED, 1'b1);
        // Separator skipped, bad second digit gives the first digit alone
        push_text("41 0D8x", REQ_SPEED, 1'b1);
        wait_for_drain();

        // Random replies, with a full drain halfway through
        queued_count = 0;
        while (queued_count < RandomItems / 2) queue_random_reply();
        wait_for_drain();
        while (queued_count < RandomItems) queue_random_reply();
        wait_for_drain();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
